/* src/dsc_pkg.sv */
// Shared types and constants for the divisible subsequence counter.
// No dependencies; compile first.
package dsc_pkg;

   localparam int DIGIT_W   = 4;
   localparam int MOD_REG_W = 8;
   localparam int OUT_W     = 32;
   localparam int RADIX     = 10;
   localparam logic [MOD_REG_W-1:0] MOD_RESET = 8'd1;

   // Control from the sequencer to the memory datapath.
   typedef struct packed {
      logic bank;      // 0: ram0 holds the live counts, ram1 is scratch
      logic wr_en;     // second stage writes scratch
      logic wr_scat;   // second stage is a scatter-add, else a copy
      logic fresh;     // live counts read as the restart pattern
      logic src_zero;  // second stage source index is remainder zero
      logic emit;      // load the result register
   } ctrl_type;

endpackage

/* src/dsc_chan_if.sv */
// Handshake channel interfaces: digit input, count result, modulus write.
// Depends on dsc_pkg.
interface dsc_req_if;
   import dsc_pkg::*;
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last_digit;
   modport source (output valid, output digit, output last_digit, input ready);
   modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface dsc_rsp_if;
   import dsc_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] divisible_count;
   modport source (output valid, output divisible_count, input ready);
   modport sink   (input valid, input divisible_count, output ready);
endinterface

interface dsc_csr_if;
   import dsc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MOD_REG_W-1:0] modulus;
   modport source (output valid, output modulus, input ready);
   modport sink   (input valid, input modulus, output ready);
endinterface

/* src/dsc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* src/dsc_seq.sv */
// Sequencer: reduces digit and radix by the modulus, then runs the copy pass
// and the scatter-add pass over the count memories. Depends on dsc_pkg.
module dsc_seq #(
   parameter int MOD_LIMIT = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dsc_pkg::DIGIT_W-1:0]      digit,
   input  logic                             last_digit,
   input  logic [dsc_pkg::MOD_REG_W-1:0]    modulus,
   input  logic                             restart,
   input  logic                             rsp_busy,
   output logic                             idle,
   output logic [$clog2(MOD_LIMIT)-1:0]     cur_raddr,
   output logic [$clog2(MOD_LIMIT)-1:0]     scr_raddr,
   output logic [$clog2(MOD_LIMIT)-1:0]     wr_addr,
   output dsc_pkg::ctrl_type                ctrl
);
   import dsc_pkg::*;

   localparam int AW = $clog2(MOD_LIMIT);
   localparam int MW = $clog2(MOD_LIMIT + 1);
   localparam int XW = (MW > DIGIT_W) ? MW : DIGIT_W;
   localparam int EW = (MW > MOD_REG_W) ? MW : MOD_REG_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_COPY = 5'b00100,
      S_SCAT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [MW-1:0]   m_ff, m_in;
   logic [XW-1:0]   d_ff, d_in;
   logic [XW-1:0]   step_ff, step_in;
   logic            last_ff, last_in;
   logic [MW-1:0]   r_ff, r_in;
   logic [MW-1:0]   t_ff, t_in;
   logic            bank_ff, bank_in;
   logic            fresh_ff, fresh_in;
   logic            p_valid_ff, p_valid_in;
   logic            p_scat_ff, p_scat_in;
   logic [AW-1:0]   p_r_ff, p_r_in;
   logic [AW-1:0]   p_t_ff, p_t_in;

   logic [EW-1:0]   mod_e;
   logic [EW-1:0]   eff_e;
   logic [XW-1:0]   m_x;
   logic            d_ge;
   logic            s_ge;
   logic            r_end;
   logic [MW:0]     t_sum;
   logic [MW-1:0]   t_next;
   logic            emit;

   always_comb begin
      mod_e = EW'(modulus);
      if (mod_e == '0) begin
         eff_e = EW'(1);
      end else if (mod_e > EW'(MOD_LIMIT)) begin
         eff_e = EW'(MOD_LIMIT);
      end else begin
         eff_e = mod_e;
      end
   end

   assign m_x   = XW'(m_ff);
   assign d_ge  = d_ff >= m_x;
   assign s_ge  = step_ff >= m_x;
   assign r_end = r_ff == (m_ff - MW'(1));
   assign t_sum = {1'b0, t_ff} + {1'b0, MW'(step_ff)};

   // step and t both lie below the modulus, so one subtract wraps the sum
   always_comb begin
      if (t_sum >= {1'b0, m_ff}) begin
         t_next = MW'(t_sum - {1'b0, m_ff});
      end else begin
         t_next = MW'(t_sum);
      end
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      r_in     = r_ff;
      t_in     = t_ff;
      bank_in  = bank_ff;
      fresh_in = fresh_ff;
      emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               m_in     = MW'(eff_e);
               d_in     = XW'(digit);
               step_in  = XW'(RADIX);
               last_in  = last_digit;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (d_ge) begin
               d_in = d_ff - m_x;
            end
            if (s_ge) begin
               step_in = step_ff - m_x;
            end
            if (!d_ge && !s_ge) begin
               t_in     = MW'(d_ff);
               r_in     = '0;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            r_in = r_ff + MW'(1);
            if (r_end) begin
               r_in     = '0;
               state_in = S_SCAT;
            end
         end
         S_SCAT: begin
            r_in = r_ff + MW'(1);
            t_in = t_next;
            if (r_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // drain the last write, then swap banks; after the last digit, hand off the count
            if (!p_valid_ff && !(last_ff && rsp_busy)) begin
               emit     = last_ff;
               bank_in  = !bank_ff;
               fresh_in = last_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (restart) begin
         fresh_in = 1'b1;
      end
   end

   assign p_valid_in = (state_ff == S_COPY) || (state_ff == S_SCAT);
   assign p_scat_in  = state_ff == S_SCAT;
   assign p_r_in     = r_ff[AW-1:0];
   assign p_t_in     = t_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         bank_ff    <= 1'b0;
         fresh_ff   <= 1'b1;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bank_ff    <= bank_in;
         fresh_ff   <= fresh_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      d_ff      <= d_in;
      step_ff   <= step_in;
      last_ff   <= last_in;
      r_ff      <= r_in;
      t_ff      <= t_in;
      p_scat_ff <= p_scat_in;
      p_r_ff    <= p_r_in;
      p_t_ff    <= p_t_in;
   end

   assign idle      = state_ff == S_IDLE;
   assign cur_raddr = r_ff[AW-1:0];
   assign scr_raddr = t_ff[AW-1:0];
   assign wr_addr   = p_scat_ff ? p_t_ff : p_r_ff;

   assign ctrl.bank     = bank_ff;
   assign ctrl.wr_en    = p_valid_ff;
   assign ctrl.wr_scat  = p_scat_ff;
   assign ctrl.fresh    = fresh_ff;
   assign ctrl.src_zero = p_r_ff == '0;
   assign ctrl.emit     = emit;
endmodule

/* src/divisible_subsequence_counter_unit.sv */
// Divisible subsequence counter: two ping-pong count memories, a sequencer
// and a read-modify-write datapath with one-entry write forwarding.
// Each digit transaction first reduces digit and radix by m, the effective
// modulus, then runs the copy pass and the scatter-add pass, one remainder
// per cycle on the count memory ports; a new digit is taken only when the
// sequencer is idle again, and the result waits while the output is held.
// Reset: modulus 1, counts at one for remainder zero; no clearing pass.
module divisible_subsequence_counter_unit #(
   parameter int MOD_LIMIT  = 128,
   parameter int COUNT_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   dsc_req_if.sink   req_chan,
   dsc_rsp_if.source rsp_chan,
   dsc_csr_if.sink   csr_chan
);
   import dsc_pkg::*;

   localparam int AW = $clog2(MOD_LIMIT);

   logic [MOD_REG_W-1:0]  modulus_ff, modulus_in;
   logic                  csr_write;
   logic                  req_take;
   logic                  idle;
   logic                  rsp_busy;
   logic [AW-1:0]         cur_raddr;
   logic [AW-1:0]         scr_raddr;
   logic [AW-1:0]         wr_addr;
   ctrl_type              ctrl;

   logic [AW-1:0]         ram0_raddr, ram1_raddr;
   logic                  ram0_we, ram1_we;
   logic [COUNT_BITS-1:0] ram0_rdata, ram1_rdata;
   logic [COUNT_BITS-1:0] cur_rdata, scr_rdata;
   logic [COUNT_BITS-1:0] cur_val, scr_val, wr_data;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]         fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] zero_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_count_ff;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign modulus_in     = csr_write ? csr_chan.modulus : modulus_ff;

   assign req_chan.ready = idle;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_busy       = rsp_valid_ff && !rsp_chan.ready;

   dsc_seq #(
      .MOD_LIMIT (MOD_LIMIT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .digit      (req_chan.digit),
      .last_digit (req_chan.last_digit),
      .modulus    (modulus_ff),
      .restart    (csr_write),
      .rsp_busy   (rsp_busy),
      .idle       (idle),
      .cur_raddr  (cur_raddr),
      .scr_raddr  (scr_raddr),
      .wr_addr    (wr_addr),
      .ctrl       (ctrl)
   );

   // bank low: ram0 live, ram1 scratch; only scratch is ever written
   assign ram0_raddr = ctrl.bank ? scr_raddr : cur_raddr;
   assign ram1_raddr = ctrl.bank ? cur_raddr : scr_raddr;
   assign ram0_we    = ctrl.wr_en && ctrl.bank;
   assign ram1_we    = ctrl.wr_en && !ctrl.bank;

   dsc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MOD_LIMIT)
   ) u_ram0 (
      .clock (clock),
      .we    (ram0_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (ram0_raddr),
      .rdata (ram0_rdata)
   );

   dsc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MOD_LIMIT)
   ) u_ram1 (
      .clock (clock),
      .we    (ram1_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (ram1_raddr),
      .rdata (ram1_rdata)
   );

   assign cur_rdata = ctrl.bank ? ram1_rdata : ram0_rdata;
   assign scr_rdata = ctrl.bank ? ram0_rdata : ram1_rdata;

   // a fresh string reads as one at remainder zero and zero elsewhere
   always_comb begin
      if (ctrl.fresh) begin
         cur_val = ctrl.src_zero ? COUNT_BITS'(1) : '0;
      end else begin
         cur_val = cur_rdata;
      end
   end

   // the write at the read's own edge missed the array: take it from the bypass
   assign scr_val      = (fwd_valid_ff && (fwd_addr_ff == wr_addr)) ? fwd_data_ff : scr_rdata;
   assign wr_data      = ctrl.wr_scat ? (scr_val + cur_val) : cur_val;
   assign fwd_valid_in = ctrl.wr_en;
   assign rsp_valid_in = ctrl.emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MOD_RESET;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      if (ctrl.wr_en && (wr_addr == '0)) begin
         zero_ff <= wr_data;
      end
      if (ctrl.emit) begin
         rsp_count_ff <= OUT_W'(zero_ff - COUNT_BITS'(1));
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.divisible_count = rsp_count_ff;

   a_emit_slot_free : assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !rsp_busy)
      else $error("result loaded while output register still held");

   a_emit_after_drain : assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !ctrl.wr_en)
      else $error("result loaded before last count write");

   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("input accepted again before digit finished");

   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.emit))
      else $error("result valid without a load");
endmodule
